/* rtl/core/sorted_priority_queue_core_assert.svh */
// Assertion macros for the sorted priority queue core.
// Used by the port checker; no other dependencies.
`ifndef SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define SPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Check a property on every clock edge, reset included.
`define SPQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* rtl/core/spq_pkg.sv */
// Shared types and codes for the sorted priority queue core.
// No dependencies; used by the cell, the top level and the checker.
package spq_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned OCC_W  = 5;

    localparam logic [1:0] OP_ENQUEUE = 2'd0;
    localparam logic [1:0] OP_DEQUEUE = 2'd1;
    localparam logic [1:0] OP_PEEK    = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic   ins;
        logic   del;
        entry_t item;
    } cmd_t;

endpackage

/* rtl/core/sorted_priority_queue_core.sv */
// Sorted priority queue core: a chain of CAPACITY cells kept in priority
// order, lowest number at the head, equal priorities first in, first out.
// One operation (enqueue, dequeue, peek) is accepted per cycle while the
// output register is empty or being read; its result is in the output register
// in the following cycle. Every cell compares its priority with the broadcast
// item in the same cycle and shifts toward or away from the head, so the rate is
// one word per cycle at any depth unless stalled. Uses spq_pkg and spq_cell.
module sorted_priority_queue_core #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_opcode,
    input  logic signed [spq_pkg::DATA_W-1:0] s_item_value,
    input  logic signed [spq_pkg::DATA_W-1:0] s_item_priority,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [1:0]                       m_status,
    output logic signed [spq_pkg::DATA_W-1:0] m_head_value,
    output logic                             m_head_valid,
    output logic [spq_pkg::OCC_W-1:0]        m_occupancy
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       m_valid_reg;
    logic [1:0]                 status_reg, status_next;
    logic signed [spq_pkg::DATA_W-1:0] head_value_reg, head_value_next;
    logic                       head_valid_reg, head_valid_next;
    logic [spq_pkg::OCC_W-1:0]  occupancy_reg;

    spq_pkg::cmd_t   cmd;
    spq_pkg::entry_t cell_entry [CAPACITY];
    logic [CAPACITY-1:0] cell_gt;
    logic [CAPACITY-1:0] cell_occ;
    logic            fire, full, empty;

    assign s_ready = aresetn && (!m_valid_reg || m_ready);
    assign fire    = s_valid && s_ready;
    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign empty   = (count_reg == '0);

    always_comb begin
        cmd.ins           = 1'b0;
        cmd.del           = 1'b0;
        cmd.item.value    = s_item_value;
        cmd.item.prio     = s_item_priority;
        count_next        = count_reg;
        status_next       = spq_pkg::ST_OK;
        head_value_next   = '0;
        head_valid_next   = 1'b0;
        case (s_opcode)
            spq_pkg::OP_ENQUEUE: begin
                if (full) begin
                    status_next = spq_pkg::ST_FULL;
                end else begin
                    cmd.ins    = fire;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            spq_pkg::OP_DEQUEUE, spq_pkg::OP_PEEK: begin
                if (empty) begin
                    status_next = spq_pkg::ST_EMPTY;
                end else begin
                    head_value_next = cell_entry[0].value;
                    head_valid_next = 1'b1;
                    if (s_opcode == spq_pkg::OP_DEQUEUE) begin
                        cmd.del    = fire;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            default: begin
                count_next = count_reg;
            end
        endcase
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        spq_pkg::entry_t right_entry;
        logic            left_occ;
        logic            left_gt;
        spq_pkg::entry_t left_entry;

        assign cell_occ[i] = (CNT_W'(i) < count_reg);

        if (i == 0) begin : g_head
            assign left_occ   = 1'b1;
            assign left_gt    = 1'b0;
            assign left_entry = '0;
        end else begin : g_body
            assign left_occ   = cell_occ[i-1];
            assign left_gt    = cell_gt[i-1];
            assign left_entry = cell_entry[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign right_entry = '0;
        end else begin : g_mid
            assign right_entry = cell_entry[i+1];
        end

        spq_cell u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .occ         (cell_occ[i]),
            .left_occ    (left_occ),
            .left_gt     (left_gt),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .gt          (cell_gt[i]),
            .entry       (cell_entry[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            status_reg     <= status_next;
            head_value_reg <= head_value_next;
            head_valid_reg <= head_valid_next;
            occupancy_reg  <= spq_pkg::OCC_W'(count_next);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = status_reg;
    assign m_head_value = head_value_reg;
    assign m_head_valid = head_valid_reg;
    assign m_occupancy  = occupancy_reg;

endmodule

/* rtl/core/spq_cell.sv */
// One slot of the sorted chain: holds an entry, compares it with the
// broadcast priority and shifts left or right with its neighbors. Uses spq_pkg.
module spq_cell (
    input  logic           aclk,
    input  spq_pkg::cmd_t  cmd,
    input  logic           occ,
    input  logic           left_occ,
    input  logic           left_gt,
    input  spq_pkg::entry_t left_entry,
    input  spq_pkg::entry_t right_entry,
    output logic           gt,
    output spq_pkg::entry_t entry
);

    spq_pkg::entry_t entry_reg;

    assign gt    = occ && ($signed(entry_reg.prio) > $signed(cmd.item.prio));
    assign entry = entry_reg;

    always_ff @(posedge aclk) begin
        if (cmd.ins) begin
            if (left_gt) begin
                entry_reg <= left_entry;
            end else if (left_occ && (gt || !occ)) begin
                entry_reg <= cmd.item;
            end
        end else if (cmd.del) begin
            entry_reg <= right_entry;
        end
    end

endmodule

/* rtl/core/spq_checker.sv */
// Port-level checks for the sorted priority queue core, bound to the top.
// Uses spq_pkg and sorted_priority_queue_core_assert.svh.
`include "sorted_priority_queue_core_assert.svh"

module spq_checker #(
    parameter int unsigned CAPACITY = 16
) (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic [1:0]                       s_opcode,
    input logic signed [spq_pkg::DATA_W-1:0] s_item_value,
    input logic signed [spq_pkg::DATA_W-1:0] s_item_priority,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [1:0]                       m_status,
    input logic signed [spq_pkg::DATA_W-1:0] m_head_value,
    input logic                             m_head_valid,
    input logic [spq_pkg::OCC_W-1:0]        m_occupancy
);

    `SPQ_ASSERT_ALWAYS(a_reset_clears_out, !aresetn |=> !m_valid, "result word after reset")

    `SPQ_ASSERT(a_head_ok, (m_valid && m_head_valid) |-> (m_status == spq_pkg::ST_OK), "head without ok status")

    `SPQ_ASSERT(a_empty_result, (m_valid && m_status == spq_pkg::ST_EMPTY) |-> (m_occupancy == '0 && !m_head_valid && m_head_value == '0), "bad empty result")

    `SPQ_ASSERT(a_full_result, (m_valid && m_status == spq_pkg::ST_FULL) |-> (m_occupancy == spq_pkg::OCC_W'(CAPACITY) && !m_head_valid), "bad full result")

endmodule

bind sorted_priority_queue_core spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (.*);
